### hdl/gtr_pkg.sv
// Shared constants, codes and font tables for the glyph text rasterizer.
// Depends on nothing; every other file refers to it by scoped names.
package gtr_pkg;

    localparam int CHAR_W      = 8;
    localparam int POS_W       = 12;
    localparam int COLOR_W     = 32;
    localparam int PIX_ADDR_W  = 24;
    localparam int BASE_W      = 24;
    localparam int PITCH_W     = 13;
    localparam int PROD_W      = POS_W + PITCH_W;
    localparam int GLYPH_IDX_W = 6;
    localparam int CELLS       = 25;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 24;
    localparam int CHAR_ADVANCE = 6;

    localparam logic [GLYPH_IDX_W-1:0] BLANK_GLYPH = 6'd45;

    localparam logic [PITCH_W-1:0] PITCH_RESET = 13'd640;
    localparam logic [BASE_W-1:0]  BASE_RESET  = '0;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH = 1'd1;

    // Shared adder operations
    localparam logic [2:0] ALU_BASE   = 3'd0;   // product + frame base
    localparam logic [2:0] ALU_X      = 3'd1;   // cursor + start column
    localparam logic [2:0] ALU_CELL   = 3'd2;   // row base + column
    localparam logic [2:0] ALU_SHADOW = 3'd3;   // cell address + pitch
    localparam logic [2:0] ALU_ROW    = 3'd4;   // row base + pitch
    localparam logic [2:0] ALU_ADV    = 3'd5;   // cursor + character advance

    typedef logic [CELLS-1:0] glyph_t;

    // Fold upper case, then map the byte onto the font's symbol order.
    function automatic logic [GLYPH_IDX_W-1:0] glyph_index(input logic [CHAR_W-1:0] code);
        logic [CHAR_W-1:0]      c;
        logic [GLYPH_IDX_W-1:0] idx;
        c = code;
        if (c >= 8'h41 && c <= 8'h5A)
            c = c + 8'h20;
        if (c >= 8'h61 && c <= 8'h7A)
            idx = GLYPH_IDX_W'(c - 8'h61);
        else if (c >= 8'h30 && c <= 8'h39)
            idx = GLYPH_IDX_W'(c - 8'h30 + 8'd26);
        else begin
            case (c)
                8'h21:   idx = 6'd36;   // !
                8'h3F:   idx = 6'd37;   // ?
                8'h3A:   idx = 6'd38;   // :
                8'h3D:   idx = 6'd39;   // =
                8'h2C:   idx = 6'd40;   // ,
                8'h2E:   idx = 6'd41;   // .
                8'h2D:   idx = 6'd42;   // -
                8'h28:   idx = 6'd43;   // (
                8'h29:   idx = 6'd44;   // )
                8'h23:   idx = 6'd46;   // #
                8'h27:   idx = 6'd47;   // apostrophe
                8'h2A:   idx = 6'd48;   // *
                8'h2F:   idx = 6'd49;   // /
                default: idx = BLANK_GLYPH;
            endcase
        end
        return idx;
    endfunction

    // 5x5 font, row-major; the top-left cell is bit 24.
    function automatic glyph_t glyph_bits(input logic [GLYPH_IDX_W-1:0] idx);
        glyph_t g;
        case (idx)
            6'd0:    g = 25'b01110_10001_11111_10001_10001;
            6'd1:    g = 25'b11110_10001_11110_10001_11110;
            6'd2:    g = 25'b01111_10000_10000_10000_01111;
            6'd3:    g = 25'b11110_10001_10001_10001_11110;
            6'd4:    g = 25'b11111_10000_11110_10000_11111;
            6'd5:    g = 25'b11111_10000_11100_10000_10000;
            6'd6:    g = 25'b01111_10000_10111_10001_01110;
            6'd7:    g = 25'b10001_10001_11111_10001_10001;
            6'd8:    g = 25'b00100_00100_00100_00100_00100;
            6'd9:    g = 25'b00010_00010_00010_00010_11100;
            6'd10:   g = 25'b10010_10100_11000_10100_10010;
            6'd11:   g = 25'b10000_10000_10000_10000_11111;
            6'd12:   g = 25'b11010_10101_10101_10001_10001;
            6'd13:   g = 25'b10001_11001_10101_10011_10001;
            6'd14:   g = 25'b01110_10001_10001_10001_01110;
            6'd15:   g = 25'b11110_10001_11110_10000_10000;
            6'd16:   g = 25'b01110_10001_10001_10011_01111;
            6'd17:   g = 25'b11110_10001_11110_10100_10010;
            6'd18:   g = 25'b01111_10000_01110_00001_11110;
            6'd19:   g = 25'b11111_00100_00100_00100_00100;
            6'd20:   g = 25'b10001_10001_10001_10001_01111;
            6'd21:   g = 25'b10001_10001_01010_01010_00100;
            6'd22:   g = 25'b10001_10001_10101_10101_01010;
            6'd23:   g = 25'b10001_01010_00100_01010_10001;
            6'd24:   g = 25'b10001_10001_01111_00001_01110;
            6'd25:   g = 25'b11111_00010_00100_01000_11111;
            6'd26:   g = 25'b01110_10011_10101_11001_01110;
            6'd27:   g = 25'b00100_01100_00100_00100_01110;
            6'd28:   g = 25'b01110_10001_00110_01000_11111;
            6'd29:   g = 25'b11110_00001_00110_00001_11110;
            6'd30:   g = 25'b10000_10010_11111_00010_00010;
            6'd31:   g = 25'b11111_10000_11110_00001_11110;
            6'd32:   g = 25'b01111_10000_11110_10001_01110;
            6'd33:   g = 25'b11111_00001_00010_00100_00100;
            6'd34:   g = 25'b01110_10001_01110_10001_01110;
            6'd35:   g = 25'b01110_10001_01111_00001_01110;
            6'd36:   g = 25'b00100_00100_00100_00000_00100;
            6'd37:   g = 25'b01110_00001_00010_00000_00100;
            6'd38:   g = 25'b00000_00000_00100_00000_00100;
            6'd39:   g = 25'b00000_00000_01110_00000_01110;
            6'd40:   g = 25'b00000_00000_00000_00010_00100;
            6'd41:   g = 25'b00000_00000_00000_00000_00100;
            6'd42:   g = 25'b00000_00000_01110_00000_00000;
            6'd43:   g = 25'b00010_00100_00100_00100_00010;
            6'd44:   g = 25'b00100_00010_00010_00010_00100;
            6'd46:   g = 25'b01010_11111_01010_11111_01010;
            6'd47:   g = 25'b00100_00100_00000_00000_00000;
            6'd48:   g = 25'b10101_01110_11111_01110_10101;
            6'd49:   g = 25'b00001_00010_00100_01000_10000;
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

### hdl/gtr_ifs.sv
// Handshake channels of the glyph text rasterizer: characters in, pixel
// writes out, and configuration writes. Depends on gtr_pkg for widths.

interface gtr_char_if;
    logic                           valid;
    logic                           ready;
    logic [gtr_pkg::CHAR_W-1:0]     char_code;
    logic                           new_string;
    logic [gtr_pkg::POS_W-1:0]      pos_x;
    logic [gtr_pkg::POS_W-1:0]      pos_y;
    logic [gtr_pkg::COLOR_W-1:0]    color;

    modport source (output valid, char_code, new_string, pos_x, pos_y, color, input ready);
    modport sink   (input valid, char_code, new_string, pos_x, pos_y, color, output ready);
endinterface

interface gtr_pix_if;
    logic                            valid;
    logic                            ready;
    logic [gtr_pkg::PIX_ADDR_W-1:0]  pixel_address;
    logic [gtr_pkg::COLOR_W-1:0]     pixel_value;
    logic                            last_write;

    modport source (output valid, pixel_address, pixel_value, last_write, input ready);
    modport sink   (input valid, pixel_address, pixel_value, last_write, output ready);
endinterface

interface gtr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gtr_pkg::CFG_IDX_W-1:0]   index;
    logic [gtr_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/gtr_cfg_regs.sv
// Configuration register file: frame base and line pitch.
// Depends on gtr_pkg and gtr_cfg_if.
module gtr_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    gtr_cfg_if.sink                        cfg,
    output logic [gtr_pkg::BASE_W-1:0]     frame_base,
    output logic [gtr_pkg::PITCH_W-1:0]    line_pitch
);

    logic [gtr_pkg::BASE_W-1:0]  base_reg;
    logic [gtr_pkg::PITCH_W-1:0] pitch_reg;

    assign cfg.ready  = 1'b1;
    assign frame_base = base_reg;
    assign line_pitch = pitch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= gtr_pkg::BASE_RESET;
            pitch_reg <= gtr_pkg::PITCH_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                gtr_pkg::CFG_FRAME_BASE: base_reg  <= cfg.data[gtr_pkg::BASE_W-1:0];
                gtr_pkg::CFG_LINE_PITCH: pitch_reg <= cfg.data[gtr_pkg::PITCH_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

### hdl/gtr_addr_alu.sv
// Shared address adder: picks two operands by operation code and adds
// them modulo 2^ADDR_BITS. Depends on gtr_pkg.
module gtr_addr_alu #(
    parameter int ADDR_BITS = 24
) (
    input  logic [2:0]                     op,
    input  logic [ADDR_BITS-1:0]           cursor,
    input  logic [ADDR_BITS-1:0]           row_base,
    input  logic [ADDR_BITS-1:0]           cell_addr,
    input  logic [gtr_pkg::PROD_W-1:0]     prod,
    input  logic [gtr_pkg::BASE_W-1:0]     frame_base,
    input  logic [gtr_pkg::PITCH_W-1:0]    line_pitch,
    input  logic [gtr_pkg::POS_W-1:0]      pos_x,
    input  logic [2:0]                     col,
    output logic [ADDR_BITS-1:0]           sum
);

    logic [ADDR_BITS-1:0] opa;
    logic [ADDR_BITS-1:0] opb;

    always_comb
    begin
        case (op)
            gtr_pkg::ALU_BASE:
            begin
                opa = ADDR_BITS'(prod);
                opb = ADDR_BITS'(frame_base);
            end
            gtr_pkg::ALU_X:
            begin
                opa = cursor;
                opb = ADDR_BITS'(pos_x);
            end
            gtr_pkg::ALU_CELL:
            begin
                opa = row_base;
                opb = ADDR_BITS'(col);
            end
            gtr_pkg::ALU_SHADOW:
            begin
                opa = cell_addr;
                opb = ADDR_BITS'(line_pitch);
            end
            gtr_pkg::ALU_ROW:
            begin
                opa = row_base;
                opb = ADDR_BITS'(line_pitch);
            end
            gtr_pkg::ALU_ADV:
            begin
                opa = cursor;
                opb = ADDR_BITS'(gtr_pkg::CHAR_ADVANCE);
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign sum = opa + opb;

endmodule

### hdl/gtr_seq.sv
// Character sequencer: computes the cursor, scans the glyph cell by cell
// and issues colour and shadow writes through the shared address adder.
// Depends on gtr_pkg, gtr_char_if, gtr_pix_if and gtr_addr_alu.
module gtr_seq #(
    parameter int ADDR_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    gtr_char_if.sink                       chars,
    gtr_pix_if.source                      pixels,
    input  logic [gtr_pkg::BASE_W-1:0]     frame_base,
    input  logic [gtr_pkg::PITCH_W-1:0]    line_pitch
);

    localparam int EXT_W = (ADDR_BITS > gtr_pkg::PIX_ADDR_W) ? ADDR_BITS : gtr_pkg::PIX_ADDR_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ADDB = 3'd2;
    localparam logic [2:0] ST_ADDX = 3'd3;
    localparam logic [2:0] ST_SCAN = 3'd4;
    localparam logic [2:0] ST_SHAD = 3'd5;
    localparam logic [2:0] ST_NROW = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    logic [2:0]                         state_reg,  state_next;
    logic [ADDR_BITS-1:0]               cursor_reg, cursor_next;
    logic [ADDR_BITS-1:0]               row_base_reg, row_base_next;
    logic [ADDR_BITS-1:0]               cell_addr_reg, cell_addr_next;
    logic [gtr_pkg::PROD_W-1:0]         prod_reg, prod_next;
    gtr_pkg::glyph_t                    glyph_reg, glyph_next;
    logic [2:0]                         row_reg, row_next;
    logic [2:0]                         col_reg, col_next;
    logic [gtr_pkg::COLOR_W-1:0]        color_reg, color_next;
    logic [gtr_pkg::POS_W-1:0]          x_reg, x_next;
    logic [gtr_pkg::POS_W-1:0]          y_reg, y_next;
    logic                               ovalid_reg, ovalid_next;
    logic [gtr_pkg::PIX_ADDR_W-1:0]     oaddr_reg, oaddr_next;
    logic [gtr_pkg::COLOR_W-1:0]        ovalue_reg, ovalue_next;
    logic                               olast_reg, olast_next;

    logic [2:0]                         alu_op;
    logic [ADDR_BITS-1:0]               alu_sum;
    logic [EXT_W-1:0]                   sum_ext;
    logic                               ofree;
    logic                               accept;

    gtr_addr_alu #(
        .ADDR_BITS (ADDR_BITS)
    ) u_alu (
        .op         (alu_op),
        .cursor     (cursor_reg),
        .row_base   (row_base_reg),
        .cell_addr  (cell_addr_reg),
        .prod       (prod_reg),
        .frame_base (frame_base),
        .line_pitch (line_pitch),
        .pos_x      (x_reg),
        .col        (col_reg),
        .sum        (alu_sum)
    );

    assign sum_ext = EXT_W'(alu_sum);
    assign ofree   = !ovalid_reg || pixels.ready;
    assign accept  = chars.valid && chars.ready;

    assign chars.ready          = (state_reg == ST_IDLE);
    assign pixels.valid         = ovalid_reg;
    assign pixels.pixel_address = oaddr_reg;
    assign pixels.pixel_value   = ovalue_reg;
    assign pixels.last_write    = olast_reg;

    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        row_base_next  = row_base_reg;
        cell_addr_next = cell_addr_reg;
        prod_next      = prod_reg;
        glyph_next     = glyph_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        color_next     = color_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        ovalid_next    = ovalid_reg && !pixels.ready;
        oaddr_next     = oaddr_reg;
        ovalue_next    = ovalue_reg;
        olast_next     = olast_reg;
        alu_op         = gtr_pkg::ALU_CELL;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    glyph_next    = gtr_pkg::glyph_bits(gtr_pkg::glyph_index(chars.char_code));
                    color_next    = chars.color;
                    x_next        = chars.pos_x;
                    y_next        = chars.pos_y;
                    row_next      = '0;
                    col_next      = '0;
                    row_base_next = cursor_reg;
                    state_next    = chars.new_string ? ST_MUL : ST_SCAN;
                end
            end
            ST_MUL:
            begin
                prod_next  = gtr_pkg::PROD_W'(y_reg) * gtr_pkg::PROD_W'(line_pitch);
                state_next = ST_ADDB;
            end
            ST_ADDB:
            begin
                alu_op      = gtr_pkg::ALU_BASE;
                cursor_next = alu_sum;
                state_next  = ST_ADDX;
            end
            ST_ADDX:
            begin
                alu_op        = gtr_pkg::ALU_X;
                cursor_next   = alu_sum;
                row_base_next = alu_sum;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                alu_op = gtr_pkg::ALU_CELL;
                if (glyph_reg == '0)
                    state_next = ST_DONE;
                else if (glyph_reg[gtr_pkg::CELLS-1])
                begin
                    if (ofree)
                    begin
                        ovalid_next    = 1'b1;
                        oaddr_next     = sum_ext[gtr_pkg::PIX_ADDR_W-1:0];
                        ovalue_next    = color_reg;
                        olast_next     = 1'b0;
                        cell_addr_next = alu_sum;
                        state_next     = ST_SHAD;
                    end
                end
                else
                begin
                    // empty cell: step to the next one
                    glyph_next = {glyph_reg[gtr_pkg::CELLS-2:0], 1'b0};
                    if (col_reg == 3'd4)
                        state_next = (row_reg == 3'd4) ? ST_DONE : ST_NROW;
                    else
                        col_next = col_reg + 3'd1;
                end
            end
            ST_SHAD:
            begin
                alu_op = gtr_pkg::ALU_SHADOW;
                if (ofree)
                begin
                    ovalid_next = 1'b1;
                    oaddr_next  = sum_ext[gtr_pkg::PIX_ADDR_W-1:0];
                    ovalue_next = '0;
                    olast_next  = (glyph_reg[gtr_pkg::CELLS-2:0] == '0);
                    glyph_next  = {glyph_reg[gtr_pkg::CELLS-2:0], 1'b0};
                    if (col_reg == 3'd4)
                        state_next = (row_reg == 3'd4) ? ST_DONE : ST_NROW;
                    else
                    begin
                        col_next   = col_reg + 3'd1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_NROW:
            begin
                alu_op        = gtr_pkg::ALU_ROW;
                row_base_next = alu_sum;
                row_next      = row_reg + 3'd1;
                col_next      = '0;
                state_next    = ST_SCAN;
            end
            ST_DONE:
            begin
                alu_op      = gtr_pkg::ALU_ADV;
                cursor_next = alu_sum;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cursor_reg <= '0;
            ovalid_reg <= 1'b0;
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            ovalid_reg <= ovalid_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_base_reg  <= row_base_next;
        cell_addr_reg <= cell_addr_next;
        prod_reg      <= prod_next;
        glyph_reg     <= glyph_next;
        color_reg     <= color_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        oaddr_reg     <= oaddr_next;
        ovalue_reg    <= ovalue_next;
        olast_reg     <= olast_next;
    end

    // A shadow always follows a set cell that has not been shifted out yet.
    a_shadow_on_set_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHAD) |-> glyph_reg[gtr_pkg::CELLS-1])
        else $error("shadow state without a set glyph cell");

    // The final write of a character is always a shadow.
    a_last_is_shadow: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && olast_reg) |-> (ovalue_reg == '0))
        else $error("last write is not a shadow");

    // Scan position stays inside the 5x5 cell grid.
    a_grid_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg <= 3'd4) && (col_reg <= 3'd4))
        else $error("glyph scan left the cell grid");

    // Cursor advance returns to idle in the next cycle.
    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> (state_reg == ST_IDLE))
        else $error("advance did not return to idle");

    // A new word on the output only appears in a scan or shadow step.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !$past(ovalid_reg)) |->
            ($past(state_reg) == ST_SCAN || $past(state_reg) == ST_SHAD))
        else $error("output word loaded outside the cell scan");

endmodule

### hdl/glyph_text_rasterizer_unit.sv
// Glyph text rasterizer top: gtr_cfg_regs and gtr_seq over the gtr_ifs channels, gtr_pkg.
// The first write follows accept once the empty cells ahead of the first lit one are
// scanned; with new_string the cursor is computed first (multiply, add base, add x).
// A new character is taken only in idle, once the last one is through; output stalls
// hold the scan. Each lit cell takes 2 adder steps, each empty cell and row 1.
// Reset: asynchronous, active low; cursor 0, frame_base 0, line_pitch 640.
module glyph_text_rasterizer_unit #(
    parameter int ADDR_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    gtr_char_if.sink    chars,
    gtr_pix_if.source   pixels,
    gtr_cfg_if.sink     cfg
);

    logic [gtr_pkg::BASE_W-1:0]  frame_base;
    logic [gtr_pkg::PITCH_W-1:0] line_pitch;

    gtr_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .frame_base (frame_base),
        .line_pitch (line_pitch)
    );

    gtr_seq #(
        .ADDR_BITS (ADDR_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .pixels     (pixels),
        .frame_base (frame_base),
        .line_pitch (line_pitch)
    );

endmodule
